@@ hdl/temporal_frame_average_macros.svh @@
// assertion helpers for the temporal frame average block
`ifndef TEMPORAL_FRAME_AVERAGE_MACROS_SVH
`define TEMPORAL_FRAME_AVERAGE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, off while in reset
`define TFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfa check failed");

// next-cycle implication, off while in reset
`define TFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfa check failed");

`else

`define TFA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/tfa_pkg.sv @@
`default_nettype none

package tfa_pkg;

    localparam int CHAN_W           = 8;
    localparam int CHAN_MAX         = 255;
    localparam int CFG_W            = 15;
    localparam int HISTORY_FRAMES_D = 5;
    localparam int MAX_PIXELS_D     = 16384;

    // chan0 in the low byte, as in the frame store
    typedef struct packed {
        logic [CHAN_W-1:0] chan2;
        logic [CHAN_W-1:0] chan1;
        logic [CHAN_W-1:0] chan0;
    } t_pixel;

    // control travelling with each pipeline stage
    typedef struct packed {
        logic valid;
        logic last;
    } t_beat;

endpackage

`default_nettype wire

@@ hdl/tfa_in_if.sv @@
`default_nettype none

interface tfa_in_if;
    logic                      valid;
    logic                      ready;
    logic [tfa_pkg::CHAN_W-1:0] chan0_in;
    logic [tfa_pkg::CHAN_W-1:0] chan1_in;
    logic [tfa_pkg::CHAN_W-1:0] chan2_in;

    modport source (output valid, output chan0_in, output chan1_in, output chan2_in,
                    input ready);
    modport sink   (input valid, input chan0_in, input chan1_in, input chan2_in,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/tfa_out_if.sv @@
`default_nettype none

interface tfa_out_if;
    logic                      valid;
    logic                      ready;
    logic [tfa_pkg::CHAN_W-1:0] chan0_out;
    logic [tfa_pkg::CHAN_W-1:0] chan1_out;
    logic [tfa_pkg::CHAN_W-1:0] chan2_out;
    logic                      frame_end;

    modport source (output valid, output chan0_out, output chan1_out, output chan2_out,
                    output frame_end, input ready);
    modport sink   (input valid, input chan0_out, input chan1_out, input chan2_out,
                    input frame_end, output ready);
endinterface

`default_nettype wire

@@ hdl/tfa_front.sv @@
`default_nettype none
`include "temporal_frame_average_macros.svh"

module tfa_front #(
    parameter int HISTORY_FRAMES = tfa_pkg::HISTORY_FRAMES_D,
    parameter int MAX_PIXELS     = tfa_pkg::MAX_PIXELS_D
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_we,
    input  logic [tfa_pkg::CFG_W-1:0]                   i_cfg_wdata,
    tfa_in_if.sink                                      i_pix,
    output tfa_pkg::t_beat                              o_beat,
    output tfa_pkg::t_pixel                             o_cur,
    output tfa_pkg::t_pixel [HISTORY_FRAMES-2:0]        o_hist,
    input  logic                                        i_ready
);
    import tfa_pkg::*;

    localparam int SLOTS  = HISTORY_FRAMES - 1;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IDX_W  = $clog2(MAX_PIXELS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int FP_W   = $clog2(MAX_PIXELS + 1);

    logic [FP_W-1:0]   r_frame_pixels;
    logic [FP_W-1:0]   n_frame_pixels;
    logic [IDX_W-1:0]  r_pix_idx;
    logic [SLOT_W-1:0] r_slot;
    logic              r_clr_busy;
    logic [IDX_W-1:0]  r_clr_addr;
    t_beat             r_beat;
    t_pixel            r_cur;

    logic              w_acc;
    logic [CNT_W-1:0]  w_idx_next;
    logic              w_last;
    t_pixel            w_in_pix;
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    t_pixel            w_wdata;
    wire t_pixel [SLOTS-1:0] w_hist;

    // register write: zero acts as one, oversize acts as the store depth
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_frame_pixels = FP_W'(1);
        end else if (32'(i_cfg_wdata) > 32'(MAX_PIXELS)) begin
            n_frame_pixels = FP_W'(MAX_PIXELS);
        end else begin
            n_frame_pixels = FP_W'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pixels <= FP_W'(MAX_PIXELS);
        end else if (i_cfg_we) begin
            r_frame_pixels <= n_frame_pixels;
        end
    end

    assign i_pix.ready = !r_clr_busy && (!r_beat.valid || i_ready);
    assign w_acc       = i_pix.valid && i_pix.ready;
    assign w_idx_next  = {1'b0, r_pix_idx} + CNT_W'(1);
    assign w_last      = w_idx_next >= CNT_W'(r_frame_pixels);
    assign w_in_pix    = '{chan2: i_pix.chan2_in, chan1: i_pix.chan1_in,
                           chan0: i_pix.chan0_in};

    // position counter and oldest-slot pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_idx <= '0;
            r_slot    <= '0;
        end else if (w_acc) begin
            if (w_last) begin
                r_pix_idx <= '0;
                r_slot    <= (r_slot == SLOT_W'(SLOTS - 1)) ? '0 : r_slot + SLOT_W'(1);
            end else begin
                r_pix_idx <= w_idx_next[IDX_W-1:0];
            end
        end
    end

    // clearing pass over the frame store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + IDX_W'(1);
            if (r_clr_addr == IDX_W'(MAX_PIXELS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign w_we    = r_clr_busy || w_acc;
    assign w_waddr = r_clr_busy ? r_clr_addr : r_pix_idx;
    assign w_wdata = r_clr_busy ? '0 : w_in_pix;

    // one memory per slot; a read returns the entry from before this cycle's write
    for (genvar s = 0; s < SLOTS; s++) begin : g_slot
        t_pixel r_mem [MAX_PIXELS];
        t_pixel r_rd;

        always_ff @(posedge i_clk) begin
            if (w_we && (r_clr_busy || r_slot == SLOT_W'(s))) begin
                r_mem[w_waddr] <= w_wdata;
            end
            if (w_acc) begin
                r_rd <= r_mem[r_pix_idx];
            end
        end

        assign w_hist[s] = r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= '0;
        end else if (!r_beat.valid || i_ready) begin
            r_beat.valid <= w_acc;
            if (w_acc) begin
                r_beat.last <= w_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cur <= w_in_pix;
        end
    end

    assign o_beat = r_beat;
    assign o_cur  = r_cur;
    assign o_hist = w_hist;

    `TFA_ASSERT_IMPL(a_no_transfer_in_clear, i_clk, i_rst_n, r_clr_busy, !i_pix.ready)
    `TFA_ASSERT_NEXT(a_idx_wraps, i_clk, i_rst_n, w_acc && w_last, r_pix_idx == '0)
    `TFA_ASSERT_NEXT(a_slot_wraps, i_clk, i_rst_n, w_acc && w_last && r_slot == SLOT_W'(SLOTS - 1), r_slot == '0)

endmodule

`default_nettype wire

@@ hdl/tfa_div.sv @@
`default_nettype none

module tfa_div #(
    parameter int HISTORY_FRAMES = tfa_pkg::HISTORY_FRAMES_D
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tfa_pkg::t_beat                       i_beat,
    input  tfa_pkg::t_pixel                      i_cur,
    input  tfa_pkg::t_pixel [HISTORY_FRAMES-2:0] i_hist,
    output logic                                 o_ready,
    output tfa_pkg::t_beat                       o_beat,
    output tfa_pkg::t_pixel                      o_cur,
    output tfa_pkg::t_pixel [HISTORY_FRAMES-2:0] o_hist,
    input  logic                                 i_ready
);
    import tfa_pkg::*;

    localparam int SLOTS       = HISTORY_FRAMES - 1;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    // ceil(2^16 / frames): exact floor quotient for any 8-bit value
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + HISTORY_FRAMES - 1) / HISTORY_FRAMES);

    t_beat                r_beat;
    t_pixel               r_cur;
    t_pixel [SLOTS-1:0]   r_hist;
    logic                 w_adv;

    function automatic logic [CHAN_W-1:0] quot(input logic [CHAN_W-1:0] x);
        logic [CHAN_W+RECIP_W-1:0] prod;
        prod = (CHAN_W + RECIP_W)'(x) * (CHAN_W + RECIP_W)'(RECIP);
        return prod[RECIP_SHIFT +: CHAN_W];
    endfunction

    function automatic t_pixel quot_pix(input t_pixel p);
        t_pixel q;
        q.chan0 = quot(p.chan0);
        q.chan1 = quot(p.chan1);
        q.chan2 = quot(p.chan2);
        return q;
    endfunction

    assign w_adv   = !r_beat.valid || i_ready;
    assign o_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= '0;
        end else if (w_adv) begin
            r_beat <= i_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_beat.valid) begin
            r_cur <= quot_pix(i_cur);
            for (int s = 0; s < SLOTS; s++) begin
                r_hist[s] <= quot_pix(i_hist[s]);
            end
        end
    end

    assign o_beat = r_beat;
    assign o_cur  = r_cur;
    assign o_hist = r_hist;

endmodule

`default_nettype wire

@@ hdl/tfa_acc.sv @@
`default_nettype none

module tfa_acc #(
    parameter int HISTORY_FRAMES = tfa_pkg::HISTORY_FRAMES_D
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tfa_pkg::t_beat                       i_beat,
    input  tfa_pkg::t_pixel                      i_cur,
    input  tfa_pkg::t_pixel [HISTORY_FRAMES-2:0] i_hist,
    output logic                                 o_ready,
    tfa_out_if.source                            o_pix
);
    import tfa_pkg::*;

    localparam int SLOTS = HISTORY_FRAMES - 1;
    localparam int SUM_W = CHAN_W + $clog2(HISTORY_FRAMES);

    t_beat       r_beat;
    t_pixel      r_out;
    t_pixel      n_out;
    logic        w_adv;

    function automatic logic [CHAN_W-1:0] sat(input logic [SUM_W-1:0] s);
        return (s > SUM_W'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX) : s[CHAN_W-1:0];
    endfunction

    always_comb begin
        logic [SUM_W-1:0] s0;
        logic [SUM_W-1:0] s1;
        logic [SUM_W-1:0] s2;
        s0 = SUM_W'(i_cur.chan0);
        s1 = SUM_W'(i_cur.chan1);
        s2 = SUM_W'(i_cur.chan2);
        for (int s = 0; s < SLOTS; s++) begin
            s0 = s0 + SUM_W'(i_hist[s].chan0);
            s1 = s1 + SUM_W'(i_hist[s].chan1);
            s2 = s2 + SUM_W'(i_hist[s].chan2);
        end
        n_out.chan0 = sat(s0);
        n_out.chan1 = sat(s1);
        n_out.chan2 = sat(s2);
    end

    assign w_adv   = !r_beat.valid || o_pix.ready;
    assign o_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= '0;
        end else if (w_adv) begin
            r_beat <= i_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_beat.valid) begin
            r_out <= n_out;
        end
    end

    assign o_pix.valid     = r_beat.valid;
    assign o_pix.chan0_out = r_out.chan0;
    assign o_pix.chan1_out = r_out.chan1;
    assign o_pix.chan2_out = r_out.chan2;
    assign o_pix.frame_end = r_beat.last;

endmodule

`default_nettype wire

@@ hdl/temporal_frame_average.sv @@
`default_nettype none

// Five-frame temporal average of a three-channel 8-bit pixel stream in raster
// order. Each output channel is the sum of value/5 (rounded down) over the
// current pixel and the same position in the four previous frames, and the
// current pixel then replaces the oldest stored frame at that position.
// frame_end marks the last pixel of each frame, whose size is set by the one
// configuration register (0 acts as 1, values above MAX_PIXELS act as
// MAX_PIXELS). One pixel is taken per clock unless the output stalls or the
// store is being cleared; a result passes through a frame-store read stage, a
// divide-by-constant stage and an add-and-saturate output register. The store
// is one single-port-write memory of MAX_PIXELS entries per stored frame, read
// and written in the same cycle. After reset the block clears all MAX_PIXELS
// entries of the store, one entry per cycle, and takes no pixel until that is
// done; register writes are taken throughout.
module temporal_frame_average #(
    parameter int HISTORY_FRAMES = tfa_pkg::HISTORY_FRAMES_D,
    parameter int MAX_PIXELS     = tfa_pkg::MAX_PIXELS_D
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [tfa_pkg::CFG_W-1:0] i_cfg_wdata,
    tfa_in_if.sink                    i_pix,
    tfa_out_if.source                 o_pix
);
    import tfa_pkg::*;

    localparam int SLOTS = HISTORY_FRAMES - 1;

    t_beat              w_f_beat;
    t_pixel             w_f_cur;
    t_pixel [SLOTS-1:0] w_f_hist;
    logic               w_d_ready;
    t_beat              w_d_beat;
    t_pixel             w_d_cur;
    t_pixel [SLOTS-1:0] w_d_hist;
    logic               w_a_ready;

    tfa_front #(
        .HISTORY_FRAMES (HISTORY_FRAMES),
        .MAX_PIXELS     (MAX_PIXELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (i_pix),
        .o_beat      (w_f_beat),
        .o_cur       (w_f_cur),
        .o_hist      (w_f_hist),
        .i_ready     (w_d_ready)
    );

    tfa_div #(
        .HISTORY_FRAMES (HISTORY_FRAMES)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (w_f_beat),
        .i_cur   (w_f_cur),
        .i_hist  (w_f_hist),
        .o_ready (w_d_ready),
        .o_beat  (w_d_beat),
        .o_cur   (w_d_cur),
        .o_hist  (w_d_hist),
        .i_ready (w_a_ready)
    );

    tfa_acc #(
        .HISTORY_FRAMES (HISTORY_FRAMES)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (w_d_beat),
        .i_cur   (w_d_cur),
        .i_hist  (w_d_hist),
        .o_ready (w_a_ready),
        .o_pix   (o_pix)
    );

endmodule

`default_nettype wire

@@ verif/tb_temporal_frame_average.sv @@
module tb_temporal_frame_average;
    import tfa_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int PIXEL_TARGET = 1650;
    localparam int MAX_GAP      = 14;
    localparam int DRAIN_CYCLES = 4;
    localparam logic [CHAN_W-1:0] CORNER_VALS [4] = '{8'd0, 8'd4, 8'd5, 8'd255};

    typedef struct packed {
        logic [CHAN_W-1:0] chan2;
        logic [CHAN_W-1:0] chan1;
        logic [CHAN_W-1:0] chan0;
        logic              frame_end;
    } t_average;

    class average_checker;
        localparam int HIST  = HISTORY_FRAMES_D;
        localparam int SLOTS = HISTORY_FRAMES_D - 1;
        localparam int DEPTH = MAX_PIXELS_D;

        logic [3*CHAN_W-1:0] past_frames [SLOTS*DEPTH];
        t_average            pending_averages [$];
        int                  frame_len;
        int                  pos;
        int                  oldest;
        int                  errors;
        int                  frames_done;

        function new();
            frame_len   = DEPTH;
            pos         = 0;
            oldest      = 0;
            errors      = 0;
            frames_done = 0;
            foreach (past_frames[i]) past_frames[i] = '0;
        endfunction

        // same clamping as the block applies to the register
        function void set_frame_len(logic [CFG_W-1:0] v);
            int n;
            n = int'(v);
            if (n == 0) n = 1;
            if (n > DEPTH) n = DEPTH;
            frame_len = n;
        endfunction

        function void take_pixel(t_pixel px);
            int                  idx;
            int                  sum;
            logic [3*CHAN_W-1:0] raw;
            logic [3*CHAN_W-1:0] entry;
            logic [CHAN_W-1:0]   avg [3];
            t_average            want;
            raw = px;
            idx = pos % DEPTH;
            for (int c = 0; c < 3; c++) begin
                sum = int'(raw[CHAN_W*c +: CHAN_W]) / HIST;
                for (int s = 0; s < SLOTS; s++) begin
                    entry = past_frames[s*DEPTH + idx];
                    sum += int'(entry[CHAN_W*c +: CHAN_W]) / HIST;
                    if (sum > CHAN_MAX) sum = CHAN_MAX;
                end
                avg[c] = sum[CHAN_W-1:0];
            end
            want.chan0     = avg[0];
            want.chan1     = avg[1];
            want.chan2     = avg[2];
            want.frame_end = (pos + 1 >= frame_len);
            past_frames[oldest*DEPTH + idx] = raw;
            if (want.frame_end) begin
                pos    = 0;
                oldest = (oldest + 1) % SLOTS;
                frames_done++;
            end else begin
                pos++;
            end
            pending_averages.push_back(want);
        endfunction

        task report(string msg);
            errors++;
            // keep the log short when everything goes wrong
            if (errors <= 60) $display("mismatch: %s", msg);
        endtask

        task compare_average(t_average got);
            t_average want;
            if (pending_averages.size() == 0) begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            want = pending_averages.pop_front();
            if (got.chan0 !== want.chan0)
                report($sformatf("chan0 got %0d want %0d", got.chan0, want.chan0));
            if (got.chan1 !== want.chan1)
                report($sformatf("chan1 got %0d want %0d", got.chan1, want.chan1));
            if (got.chan2 !== want.chan2)
                report($sformatf("chan2 got %0d want %0d", got.chan2, want.chan2));
            if (got.frame_end !== want.frame_end)
                report($sformatf("frame_end got %0b want %0b", got.frame_end, want.frame_end));
        endtask
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;

    tfa_in_if  in_if ();
    tfa_out_if out_if ();

    average_checker sb;
    t_average       seen_avg;
    bit             tx_gappy     = 1'b1;
    bit             rx_gappy     = 1'b1;
    bit             hold_off_req = 1'b0;
    int             pixels_sent  = 0;
    int             phases_run   = 0;
    int             cfg_writes   = 0;
    int             biggest_frame = 0;
    int             longest_hold = 0;

    temporal_frame_average dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (in_if),
        .o_pix       (out_if)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                seen_avg.chan0     = out_if.chan0_out;
                seen_avg.chan1     = out_if.chan1_out;
                seen_avg.chan2     = out_if.chan2_out;
                seen_avg.frame_end = out_if.frame_end;
                sb.compare_average(seen_avg);
            end
            if (in_if.valid && in_if.ready) begin
                sb.take_pixel({in_if.chan2_in, in_if.chan1_in, in_if.chan0_in});
                pixels_sent++;
            end
        end
    end

    function automatic t_pixel px_of(int c0, int c1, int c2);
        t_pixel px;
        px.chan0 = c0[CHAN_W-1:0];
        px.chan1 = c1[CHAN_W-1:0];
        px.chan2 = c2[CHAN_W-1:0];
        return px;
    endfunction

    function automatic t_pixel make_pixel(int mode);
        t_pixel px;
        case (mode)
            2: px = px_of($urandom_range(200, 255), $urandom_range(200, 255),
                          $urandom_range(200, 255));
            3: px = px_of(CORNER_VALS[$urandom_range(0, 3)], CORNER_VALS[$urandom_range(0, 3)],
                          CORNER_VALS[$urandom_range(0, 3)]);
            default: px = t_pixel'($urandom_range(0, 2**(3*CHAN_W) - 1));
        endcase
        return px;
    endfunction

    task automatic send_pixel(t_pixel px);
        int gap;
        gap = tx_gappy ? $urandom_range(0, MAX_GAP) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_if.valid = 1'b0;
        end
        @(negedge i_clk);
        in_if.valid    = 1'b1;
        in_if.chan0_in = px.chan0;
        in_if.chan1_in = px.chan1;
        in_if.chan2_in = px.chan2;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
    endtask

    // drop valid and let every outstanding average come back
    task automatic finish_phase();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (sb.pending_averages.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        phases_run++;
    endtask

    task automatic write_frame_len(logic [CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        sb.set_frame_len(v);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        cfg_writes++;
        if (sb.frame_len > biggest_frame) biggest_frame = sb.frame_len;
    endtask

    initial begin : sink_side
        int gap;
        out_if.ready = 1'b0;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                @(negedge i_clk);
                out_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                longest_hold = HOLD_CYCLES;
            end
            gap = rx_gappy ? $urandom_range(0, MAX_GAP) : 0;
            repeat (gap) begin
                @(negedge i_clk);
                out_if.ready = 1'b0;
            end
            @(negedge i_clk);
            out_if.ready = 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
        end
    end

    initial begin : stimulus
        int n_items;
        int pick;
        int content;
        int cfg_val;
        sb = new();
        in_if.valid    = 1'b0;
        in_if.chan0_in = '0;
        in_if.chan1_in = '0;
        in_if.chan2_in = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        biggest_frame = sb.frame_len;

        // reset frame size, empty history, channel extremes and divide boundaries
        send_pixel(px_of(0, 0, 0));
        send_pixel(px_of(255, 255, 255));
        send_pixel(px_of(4, 5, 9));
        send_pixel(px_of(5, 4, 10));
        send_pixel(px_of(255, 0, 170));
        send_pixel(px_of(0, 255, 85));
        send_pixel(px_of(1, 2, 3));
        send_pixel(px_of(254, 253, 252));
        finish_phase();

        // shrink below the current position, then five full-scale frames
        write_frame_len(CFG_W'(2));
        repeat (12) send_pixel(px_of(255, 255, 255));
        finish_phase();

        // zero acts as one pixel per frame
        write_frame_len('0);
        send_pixel(px_of(255, 0, 255));
        send_pixel(px_of(0, 255, 0));
        send_pixel(px_of(128, 64, 32));
        finish_phase();

        // oversize value clamps to the largest frame
        write_frame_len('1);
        send_pixel(px_of(17, 34, 51));
        send_pixel(px_of(250, 5, 99));
        finish_phase();

        while (pixels_sent < PIXEL_TARGET) begin
            pick = $urandom_range(0, 19);
            if (pick < 13)
                cfg_val = $urandom_range(1, 12);
            else if (pick < 17)
                cfg_val = $urandom_range(13, 64);
            else if (pick == 17)
                cfg_val = $urandom_range(0, 1);
            else if (pick == 18)
                cfg_val = MAX_PIXELS_D + $urandom_range(0, 1);
            else
                cfg_val = $urandom_range(0, 2**CFG_W - 1);
            write_frame_len(cfg_val[CFG_W-1:0]);
            tx_gappy = ($urandom_range(0, 3) != 0);
            rx_gappy = ($urandom_range(0, 3) != 0);
            // first random phase: sink stalls while the source keeps offering
            if (phases_run == 4) begin
                tx_gappy     = 1'b0;
                hold_off_req = 1'b1;
            end
            content = $urandom_range(0, 3);
            n_items = $urandom_range(40, 160);
            repeat (n_items) send_pixel(make_pixel(content));
            finish_phase();
        end

        repeat (10) @(posedge i_clk);
        $display("run covered %0d pixels over %0d phases, %0d frame ends, %0d size writes",
                 pixels_sent, phases_run, sb.frames_done, cfg_writes);
        $display("largest frame %0d pixels, sink hold-off %0d cycles, %0d mismatches",
                 biggest_frame, longest_hold, sb.errors);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("timeout with %0d averages outstanding", sb.pending_averages.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
